[rtl/core/cecfr_pkg.sv]
// shared types and timing constants for the cec frame receiver
`timescale 1ns / 1ps
`default_nettype none

package cecfr_pkg;

  // receiver phase codes
  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_START_LOW  = 3'd1,
    PH_START_HIGH = 3'd2,
    PH_BIT_LOW    = 3'd3,
    PH_BIT_HIGH   = 3'd4,
    PH_ACK        = 3'd5,
    PH_WAIT_BIT   = 3'd6
  } phase_t;

  // pulse timing windows in 100 us ticks
  localparam logic [5:0] START_LOW_MIN  = 6'd35;
  localparam logic [5:0] START_LOW_MAX  = 6'd39;
  localparam logic [5:0] START_TOT_MIN  = 6'd43;
  localparam logic [5:0] START_TOT_MAX  = 6'd47;
  localparam logic [5:0] ZERO_LOW_MIN   = 6'd14;
  localparam logic [5:0] ZERO_LOW_MAX   = 6'd17;
  localparam logic [5:0] ONE_LOW_MIN    = 6'd5;
  localparam logic [5:0] ONE_LOW_MAX    = 6'd8;
  localparam logic [5:0] BIT_TOT_MIN    = 6'd20;
  localparam logic [5:0] BIT_TOT_MAX    = 6'd27;

  // acknowledge hold after the first low tick, and bits per byte incl. eom
  localparam logic [4:0] ACK_HOLD       = 5'd14;
  localparam logic [3:0] BITS_PER_BYTE  = 4'd9;
  localparam logic [3:0] DATA_BITS      = 4'd8;

  // output beat payload, drive_low in the lowest bit
  typedef struct packed {
    logic [3:0] initiator_address;
    logic       frame_ok;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       drive_low;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/cec_frame_receiver_core.sv]
// cec follower frame receiver core: pulse timing, bit decode, ack drive
`timescale 1ns / 1ps
`default_nettype none

// CEC follower receiver. Each input beat carries one line sample taken at a
// 100 us tick; each accepted beat yields one registered output beat with the
// acknowledge drive, an optional data byte and, on the last beat of a frame
// (tlast), the frame status and the initiator address. The block takes one
// beat per clock: the whole pulse timing and bit decode step is one pass of
// logic between the state registers and the output register, and the input
// stays ready while the output register is empty or being drained. The user
// writes own_address via cfg_we / cfg_wdata only while idle (not enforced).
module cec_frame_receiver_core
  import cecfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,     // own_address
  // sample stream in
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [0] line_level, [7:1] zero
  // result stream out
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,  // [0] drive_low, [1] byte_valid,
                                          // [9:2] data_byte, [10] frame_ok,
                                          // [14:11] initiator_address, [15] 0
  output      logic        m_axis_tlast   // frame_done
);

  // state registers
  phase_t     phase, phase_next;
  logic [5:0] tick_count, tick_count_next;
  logic [3:0] bit_index, bit_index_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic       header_seen, header_seen_next;
  logic       eom_flag, eom_flag_next;
  logic [3:0] initiator_reg, initiator_reg_next;
  logic [4:0] ack_count, ack_count_next;
  logic       last_level;
  logic [3:0] own_address;

  // result register
  result_t    res, res_next;
  logic       done, done_next;
  logic       ok_next;

  logic       accept;
  logic       line;
  logic       fall;
  logic       end_now;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign line          = s_axis_tdata[0];
  assign fall          = last_level && !line;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= '0;
    end else if (cfg_we) begin
      own_address <= cfg_wdata;
    end
  end

  // next state and result for one sample
  always_comb begin
    logic [3:0] idx_inc;
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    shift_byte_next    = shift_byte;
    header_seen_next   = header_seen;
    eom_flag_next      = eom_flag;
    initiator_reg_next = initiator_reg;
    ack_count_next     = ack_count;
    res_next           = '0;
    end_now            = 1'b0;
    ok_next            = 1'b0;
    idx_inc            = bit_index + 4'd1;

    unique case (phase)
      PH_START_LOW: begin
        if (!line) begin
          tick_count_next = tick_count + 6'd1;
          if (tick_count_next > START_LOW_MAX) phase_next = PH_IDLE;
        end else if (tick_count < START_LOW_MIN) begin
          phase_next = PH_IDLE;
        end else begin
          tick_count_next = tick_count + 6'd1;
          phase_next      = PH_START_HIGH;
        end
      end
      PH_START_HIGH: begin
        if (line) begin
          tick_count_next = tick_count + 6'd1;
          if (tick_count_next > START_TOT_MAX) phase_next = PH_IDLE;
        end else if (tick_count < START_TOT_MIN) begin
          phase_next = PH_IDLE;
        end else begin
          bit_index_next     = '0;
          shift_byte_next    = '0;
          header_seen_next   = 1'b0;
          eom_flag_next      = 1'b0;
          initiator_reg_next = '0;
          phase_next         = PH_BIT_LOW;
          tick_count_next    = 6'd1;
        end
      end
      PH_BIT_LOW: begin
        if (!line) begin
          tick_count_next = tick_count + 6'd1;
          if (tick_count_next > ZERO_LOW_MAX) begin
            end_now    = 1'b1;
            phase_next = PH_IDLE;
          end
        end else if ((tick_count >= ZERO_LOW_MIN && tick_count <= ZERO_LOW_MAX) ||
                     (tick_count >= ONE_LOW_MIN && tick_count <= ONE_LOW_MAX)) begin
          // short low is a one, long low is a zero
          if (bit_index < DATA_BITS) begin
            shift_byte_next = {shift_byte[6:0], (tick_count <= ONE_LOW_MAX)};
          end else begin
            eom_flag_next = (tick_count <= ONE_LOW_MAX);
          end
          tick_count_next = tick_count + 6'd1;
          phase_next      = PH_BIT_HIGH;
        end else begin
          end_now    = 1'b1;
          phase_next = PH_IDLE;
        end
      end
      PH_BIT_HIGH: begin
        if (line) begin
          tick_count_next = tick_count + 6'd1;
          if (tick_count_next > BIT_TOT_MAX) begin
            end_now    = 1'b1;
            phase_next = PH_IDLE;
          end
        end else if (tick_count < BIT_TOT_MIN) begin
          end_now    = 1'b1;
          phase_next = PH_IDLE;
        end else begin
          bit_index_next = idx_inc;
          if (idx_inc < BITS_PER_BYTE) begin
            phase_next      = PH_BIT_LOW;
            tick_count_next = 6'd1;
          end else if (!header_seen && (shift_byte[3:0] != own_address)) begin
            // header for another follower
            initiator_reg_next = shift_byte[7:4];
            header_seen_next   = 1'b1;
            end_now            = 1'b1;
            phase_next         = PH_IDLE;
          end else begin
            if (!header_seen) begin
              initiator_reg_next = shift_byte[7:4];
              header_seen_next   = 1'b1;
            end else begin
              res_next.byte_valid = 1'b1;
              res_next.data_byte  = shift_byte;
            end
            res_next.drive_low = 1'b1;
            ack_count_next     = ACK_HOLD;
            phase_next         = PH_ACK;
            if (eom_flag) begin
              end_now = 1'b1;
              ok_next = 1'b1;
            end
          end
        end
      end
      PH_ACK: begin
        if (ack_count != 5'd0) begin
          res_next.drive_low = 1'b1;
          ack_count_next     = ack_count - 5'd1;
        end
        if (ack_count_next == 5'd0) begin
          phase_next = eom_flag ? PH_IDLE : PH_WAIT_BIT;
        end
      end
      PH_WAIT_BIT: begin
        if (fall) begin
          bit_index_next  = '0;
          shift_byte_next = '0;
          phase_next      = PH_BIT_LOW;
          tick_count_next = 6'd1;
        end
      end
      default: begin
        if (fall) begin
          phase_next      = PH_START_LOW;
          tick_count_next = 6'd1;
        end else begin
          phase_next = PH_IDLE;
        end
      end
    endcase

    // frame status on the closing beat
    done_next = end_now;
    if (end_now) begin
      res_next.frame_ok          = ok_next;
      res_next.initiator_address = header_seen_next ? initiator_reg_next : 4'd0;
    end
  end

  // state update on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      header_seen   <= 1'b0;
      eom_flag      <= 1'b0;
      initiator_reg <= '0;
      ack_count     <= '0;
      last_level    <= 1'b1;
    end else if (accept) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      header_seen   <= header_seen_next;
      eom_flag      <= eom_flag_next;
      initiator_reg <= initiator_reg_next;
      ack_count     <= ack_count_next;
      last_level    <= line;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res  <= res_next;
      done <= done_next;
    end
  end

  assign m_axis_tdata = {1'b0, res};
  assign m_axis_tlast = done;

  // frame_ok only ever comes with the end of a frame
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tlast)
    else $error("frame_ok without frame_done");

  // a delivered data byte is always acknowledged on the same beat
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("data byte without acknowledge drive");

  // the ack phase always holds a live countdown
  assert property (@(posedge clk) disable iff (rst)
    phase == PH_ACK |-> (ack_count != 5'd0) && (ack_count <= ACK_HOLD))
    else $error("ack countdown out of range");

  // a frame never closes while we keep acknowledging a previous one
  assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_ACK |=> !(m_axis_tlast && !m_axis_tdata[0]))
    else $error("frame end during acknowledge slot");

`default_nettype wire
endmodule
